// ----- rtl/mcdk_pkg.sv -----
// Shared types, constants and helper functions for the multiplexed clock display.
`default_nettype none
package mcdk_pkg;

  localparam int DIGITS            = 6;
  localparam int POS_W             = 3;
  localparam int TPS_W             = 16;
  localparam int KEY_HISTORY_DEPTH = 3;

  localparam logic [TPS_W-1:0] TPS_RESET  = 16'd960;
  localparam logic [4:0]       HOUR_RESET = 5'd14;
  localparam logic [5:0]       MIN_RESET  = 6'd20;
  localparam logic [5:0]       SEC_RESET  = 6'd56;

  localparam logic [5:0] SEC_TOP  = 6'd59;
  localparam logic [5:0] MIN_TOP  = 6'd59;
  localparam logic [4:0] HOUR_TOP = 5'd23;

  localparam logic [POS_W-1:0] LAST_POS = 3'd5;

  // key combinations, bit k = key read while digit k is selected
  localparam logic [DIGITS-1:0] KEY_SEC_UP   = 6'h05;
  localparam logic [DIGITS-1:0] KEY_SEC_DOWN = 6'h06;
  localparam logic [DIGITS-1:0] KEY_MIN_UP   = 6'h09;
  localparam logic [DIGITS-1:0] KEY_MIN_DOWN = 6'h0A;
  localparam logic [DIGITS-1:0] KEY_HR_UP    = 6'h21;
  localparam logic [DIGITS-1:0] KEY_HR_DOWN  = 6'h22;

  typedef enum logic [2:0] {
    ADJ_NONE     = 3'd0,
    ADJ_SEC_UP   = 3'd1,
    ADJ_SEC_DOWN = 3'd2,
    ADJ_MIN_UP   = 3'd3,
    ADJ_MIN_DOWN = 3'd4,
    ADJ_HR_UP    = 3'd5,
    ADJ_HR_DOWN  = 3'd6
  } adj_op_t;

  typedef struct packed {
    adj_op_t op;
  } key_cmd_t;

  // segments g..a, bit0 = a
  function automatic logic [6:0] seg_font(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'b0111111;
      4'd1:    p = 7'b0000110;
      4'd2:    p = 7'b1011011;
      4'd3:    p = 7'b1001111;
      4'd4:    p = 7'b1100110;
      4'd5:    p = 7'b1101101;
      4'd6:    p = 7'b1111101;
      4'd7:    p = 7'b0000111;
      4'd8:    p = 7'b1111111;
      4'd9:    p = 7'b1101111;
      default: p = 7'b0000000;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] tens6(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units6(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] d;
    d = v - ({3'b000, t} << 3) - ({3'b000, t} << 1);
    return d[3:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/multiplexed_clock_display_keys.sv -----
// Top level: six-digit multiplexed clock display with key-scan time setting.
//
//   channel | dir | handshake         | payload
//   in_     | in  | in_tvalid/tready  | in_tdata[7:0]: tick, key_sense
//   out_    | out | out_tvalid/tready | out_tdata[31:0]: select, pattern, h, m, s
//   cfg_    | in  | cfg_wr_en         | cfg_wr_data[15:0]: ticks_per_second
//
// One word per clock unless stalled: each accepted input word is registered as
// its result word in the next cycle. The input is taken whenever the output
// register is empty or being drained, so a stall on out_tready holds one word
// and back-pressures in_tready. Synchronous reset loads 14:20:56 and 960 ticks/s.
`default_nettype none
module multiplexed_clock_display_keys (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] tick, [1] key_sense, [7:2] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [5:0] digit_select, [12:6] segment_pattern,
                                       // [17:13] hours, [23:18] minutes,
                                       // [29:24] seconds, [31:30] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic                        step_en;
  logic [mcdk_pkg::POS_W-1:0]  scan_pos;
  logic [mcdk_pkg::DIGITS-1:0] select;
  logic [6:0]                  pattern;
  logic [4:0]                  hours, hours_nxt;
  logic [5:0]                  minutes, minutes_nxt, seconds, seconds_nxt;
  mcdk_pkg::key_cmd_t          cmd;
  logic                        out_valid_r;
  logic [31:0]                 out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step_en   = in_tvalid && in_tready;

  mcdk_display u_display (
    .scan_pos (scan_pos),
    .hours    (hours),
    .minutes  (minutes),
    .seconds  (seconds),
    .select   (select),
    .pattern  (pattern)
  );

  mcdk_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .key_sense (in_tdata[1]),
    .select    (select),
    .scan_pos  (scan_pos),
    .cmd       (cmd)
  );

  mcdk_time u_time (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .cfg_we      (cfg_wr_en),
    .cfg_data    (cfg_wr_data),
    .cmd         (cmd),
    .hours       (hours),
    .minutes     (minutes),
    .seconds     (seconds),
    .hours_nxt   (hours_nxt),
    .minutes_nxt (minutes_nxt),
    .seconds_nxt (seconds_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= {2'b00, seconds_nxt, minutes_nxt, hours_nxt, pattern, select};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/mcdk_display.sv -----
// Digit select decode and seven-segment pattern for the current scan position.
`default_nettype none
module mcdk_display (
  input  wire logic [mcdk_pkg::POS_W-1:0]  scan_pos,
  input  wire logic [4:0]                  hours,
  input  wire logic [5:0]                  minutes,
  input  wire logic [5:0]                  seconds,
  output logic      [mcdk_pkg::DIGITS-1:0] select,
  output logic      [6:0]                  pattern
);

  logic [mcdk_pkg::POS_W-1:0] pos_eff;
  logic [2:0] sec_t, min_t, hr_t;
  logic [3:0] digit;

  always_comb begin
    pos_eff = (scan_pos > mcdk_pkg::LAST_POS) ? '0 : scan_pos;
    select  = mcdk_pkg::DIGITS'(1) << pos_eff;
    sec_t   = mcdk_pkg::tens6(seconds);
    min_t   = mcdk_pkg::tens6(minutes);
    hr_t    = mcdk_pkg::tens6({1'b0, hours});
    unique case (pos_eff)
      3'd0:    digit = mcdk_pkg::units6(seconds, sec_t);
      3'd1:    digit = {1'b0, sec_t};
      3'd2:    digit = mcdk_pkg::units6(minutes, min_t);
      3'd3:    digit = {1'b0, min_t};
      3'd4:    digit = mcdk_pkg::units6({1'b0, hours}, hr_t);
      3'd5:    digit = {1'b0, hr_t};
      default: digit = 4'd0;
    endcase
    pattern = mcdk_pkg::seg_font(digit);
  end

endmodule
`default_nettype wire

// ----- rtl/mcdk_keys.sv -----
// Scan position, key accumulator, combination history and adjust decode.
`default_nettype none
module mcdk_keys (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step_en,
  input  wire logic                        key_sense,
  input  wire logic [mcdk_pkg::DIGITS-1:0] select,
  output logic      [mcdk_pkg::POS_W-1:0]  scan_pos,
  output mcdk_pkg::key_cmd_t               cmd
);

  logic [mcdk_pkg::POS_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [mcdk_pkg::DIGITS-1:0] acc_r, acc_nxt, acc_new;
  logic [mcdk_pkg::DIGITS-1:0] hist_r   [mcdk_pkg::KEY_HISTORY_DEPTH];
  logic [mcdk_pkg::DIGITS-1:0] hist_nxt [mcdk_pkg::KEY_HISTORY_DEPTH];
  logic wrap, fire, fresh;
  mcdk_pkg::adj_op_t op;

  assign wrap = select[mcdk_pkg::DIGITS-1];

  always_comb begin
    acc_new = acc_r | (key_sense ? select : '0);
    fire    = wrap && (acc_new != '0);
    fresh   = 1'b1;
    for (int i = 0; i < mcdk_pkg::KEY_HISTORY_DEPTH; i++) begin
      if (hist_r[i] == acc_new) fresh = 1'b0;
    end

    unique case (acc_new)
      mcdk_pkg::KEY_SEC_UP:   op = mcdk_pkg::ADJ_SEC_UP;
      mcdk_pkg::KEY_SEC_DOWN: op = mcdk_pkg::ADJ_SEC_DOWN;
      mcdk_pkg::KEY_MIN_UP:   op = mcdk_pkg::ADJ_MIN_UP;
      mcdk_pkg::KEY_MIN_DOWN: op = mcdk_pkg::ADJ_MIN_DOWN;
      mcdk_pkg::KEY_HR_UP:    op = mcdk_pkg::ADJ_HR_UP;
      mcdk_pkg::KEY_HR_DOWN:  op = mcdk_pkg::ADJ_HR_DOWN;
      default:                op = mcdk_pkg::ADJ_NONE;
    endcase
    cmd.op = (fire && fresh) ? op : mcdk_pkg::ADJ_NONE;

    // out-of-range position restarts at digit 0 and moves on to 1
    if (wrap)                                scan_pos_nxt = '0;
    else if (scan_pos_r > mcdk_pkg::LAST_POS) scan_pos_nxt = 3'd1;
    else                                     scan_pos_nxt = scan_pos_r + 3'd1;

    acc_nxt = wrap ? '0 : acc_new;

    for (int i = 0; i < mcdk_pkg::KEY_HISTORY_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (fire) begin
      for (int i = mcdk_pkg::KEY_HISTORY_DEPTH - 1; i > 0; i--) begin
        hist_nxt[i] = hist_r[i-1];
      end
      hist_nxt[0] = acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
      acc_r      <= '0;
      for (int i = 0; i < mcdk_pkg::KEY_HISTORY_DEPTH; i++) hist_r[i] <= '0;
    end else if (step_en) begin
      scan_pos_r <= scan_pos_nxt;
      acc_r      <= acc_nxt;
      for (int i = 0; i < mcdk_pkg::KEY_HISTORY_DEPTH; i++) hist_r[i] <= hist_nxt[i];
    end
  end

  assign scan_pos = scan_pos_r;

endmodule
`default_nettype wire

// ----- rtl/mcdk_time.sv -----
// Tick counter, rate register and time-of-day counters with key adjust.
`default_nettype none
module mcdk_time (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step_en,
  input  wire logic                       cfg_we,
  input  wire logic [mcdk_pkg::TPS_W-1:0] cfg_data,
  input  wire mcdk_pkg::key_cmd_t         cmd,
  output logic      [4:0]                 hours,
  output logic      [5:0]                 minutes,
  output logic      [5:0]                 seconds,
  output logic      [4:0]                 hours_nxt,
  output logic      [5:0]                 minutes_nxt,
  output logic      [5:0]                 seconds_nxt
);

  logic [mcdk_pkg::TPS_W-1:0] tps_r;
  logic [mcdk_pkg::TPS_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [4:0] hours_r;
  logic [5:0] minutes_r, seconds_r;
  logic [4:0] h_adj;
  logic [5:0] m_adj, s_adj;
  logic [6:0] s_inc, m_inc;
  logic [5:0] h_inc;
  logic       due;

  always_comb begin
    tick_inc = tick_r + 16'd1;
    due      = tick_inc >= tps_r;
    tick_nxt = due ? tick_inc - tps_r : tick_inc;

    h_adj = hours_r;
    m_adj = minutes_r;
    s_adj = seconds_r;
    case (cmd.op)
      mcdk_pkg::ADJ_SEC_UP:
        s_adj = (seconds_r >= mcdk_pkg::SEC_TOP) ? '0 : seconds_r + 6'd1;
      mcdk_pkg::ADJ_SEC_DOWN:
        s_adj = (seconds_r == '0 || seconds_r > mcdk_pkg::SEC_TOP) ?
                mcdk_pkg::SEC_TOP : seconds_r - 6'd1;
      mcdk_pkg::ADJ_MIN_UP:
        m_adj = (minutes_r >= mcdk_pkg::MIN_TOP) ? '0 : minutes_r + 6'd1;
      mcdk_pkg::ADJ_MIN_DOWN:
        m_adj = (minutes_r == '0 || minutes_r > mcdk_pkg::MIN_TOP) ?
                mcdk_pkg::MIN_TOP : minutes_r - 6'd1;
      mcdk_pkg::ADJ_HR_UP:
        h_adj = (hours_r >= mcdk_pkg::HOUR_TOP) ? '0 : hours_r + 5'd1;
      mcdk_pkg::ADJ_HR_DOWN:
        h_adj = (hours_r == '0 || hours_r > mcdk_pkg::HOUR_TOP) ?
                mcdk_pkg::HOUR_TOP : hours_r - 5'd1;
      default: ;
    endcase

    // one-second advance with carry, after any key adjust
    s_inc       = {1'b0, s_adj} + 7'd1;
    m_inc       = {1'b0, m_adj} + 7'd1;
    h_inc       = {1'b0, h_adj} + 6'd1;
    seconds_nxt = s_adj;
    minutes_nxt = m_adj;
    hours_nxt   = h_adj;
    if (due) begin
      if (s_inc >= 7'd60) begin
        seconds_nxt = '0;
        if (m_inc >= 7'd60) begin
          minutes_nxt = '0;
          hours_nxt   = (h_inc >= 6'd24) ? '0 : h_inc[4:0];
        end else begin
          minutes_nxt = m_inc[5:0];
        end
      end else begin
        seconds_nxt = s_inc[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= mcdk_pkg::TPS_RESET;
      tick_r    <= '0;
      hours_r   <= mcdk_pkg::HOUR_RESET;
      minutes_r <= mcdk_pkg::MIN_RESET;
      seconds_r <= mcdk_pkg::SEC_RESET;
    end else begin
      if (cfg_we) tps_r <= cfg_data;
      if (step_en) begin
        tick_r    <= tick_nxt;
        hours_r   <= hours_nxt;
        minutes_r <= minutes_nxt;
        seconds_r <= seconds_nxt;
      end
    end
  end

  assign hours   = hours_r;
  assign minutes = minutes_r;
  assign seconds = seconds_r;

endmodule
`default_nettype wire

// ----- rtl/mcdk_checker.sv -----
// Port-level checks for the clock display and their binding to the top level.
`default_nettype none
module mcdk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a held word must not change while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed during stall");

  // every accepted input word shows up on the output next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no output");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[5:0]))
    else $error("digit select not one-hot");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:13] <= 5'd23) && (out_tdata[23:18] <= 6'd59) &&
                   (out_tdata[29:24] <= 6'd59))
    else $error("time field out of range");

endmodule

bind multiplexed_clock_display_keys mcdk_checker u_mcdk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- verif/tb_multiplexed_clock_display_keys.sv -----
// Self-checking testbench for the multiplexed clock display with key-scan time setting.
module tb_multiplexed_clock_display_keys;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  // segments g..a for digits 0..9, bit0 = a
  localparam logic [6:0] DIGIT_FONT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  localparam logic [mcdk_pkg::DIGITS-1:0] TIME_KEYS [6] = '{
    mcdk_pkg::KEY_SEC_UP, mcdk_pkg::KEY_SEC_DOWN, mcdk_pkg::KEY_MIN_UP,
    mcdk_pkg::KEY_MIN_DOWN, mcdk_pkg::KEY_HR_UP, mcdk_pkg::KEY_HR_DOWN
  };

  typedef struct packed {
    logic [5:0] digit_select;
    logic [6:0] segment_pattern;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } display_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [0] tick, [1] key_sense, [7:2] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [5:0] select, [12:6] pattern, [17:13] hours,
                                  // [23:18] minutes, [29:24] seconds
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  multiplexed_clock_display_keys dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock model state
  logic [mcdk_pkg::TPS_W-1:0]  rate = mcdk_pkg::TPS_RESET;
  logic [4:0]                  hr = mcdk_pkg::HOUR_RESET;
  logic [5:0]                  mn = mcdk_pkg::MIN_RESET;
  logic [5:0]                  sc = mcdk_pkg::SEC_RESET;
  logic [mcdk_pkg::TPS_W-1:0]  tick_cnt = '0;
  logic [mcdk_pkg::POS_W-1:0]  scan_pos = '0;
  logic [mcdk_pkg::DIGITS-1:0] key_acc = '0;
  logic [mcdk_pkg::DIGITS-1:0] key_hist [mcdk_pkg::KEY_HISTORY_DEPTH] = '{default: '0};

  logic [7:0]    scan_ticks_pending [$];
  display_word_t display_words_due [$];

  int  snd_idle = 0;
  int  rcv_idle = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  in_sent = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // history check, then the time step a fresh two-key combination asks for
  function automatic void apply_keys();
    bit fresh;
    fresh = 1'b1;
    for (int i = 0; i < mcdk_pkg::KEY_HISTORY_DEPTH; i++)
      if (key_hist[i] == key_acc) fresh = 1'b0;
    if (fresh) begin
      case (key_acc)
        mcdk_pkg::KEY_SEC_UP:
          sc = (sc >= mcdk_pkg::SEC_TOP) ? 6'd0 : sc + 6'd1;
        mcdk_pkg::KEY_SEC_DOWN:
          sc = (sc == 0 || sc > mcdk_pkg::SEC_TOP) ? mcdk_pkg::SEC_TOP : sc - 6'd1;
        mcdk_pkg::KEY_MIN_UP:
          mn = (mn >= mcdk_pkg::MIN_TOP) ? 6'd0 : mn + 6'd1;
        mcdk_pkg::KEY_MIN_DOWN:
          mn = (mn == 0 || mn > mcdk_pkg::MIN_TOP) ? mcdk_pkg::MIN_TOP : mn - 6'd1;
        mcdk_pkg::KEY_HR_UP:
          hr = (hr >= mcdk_pkg::HOUR_TOP) ? 5'd0 : hr + 5'd1;
        mcdk_pkg::KEY_HR_DOWN:
          hr = (hr == 0 || hr > mcdk_pkg::HOUR_TOP) ? mcdk_pkg::HOUR_TOP : hr - 5'd1;
        default: ;
      endcase
    end
    for (int i = mcdk_pkg::KEY_HISTORY_DEPTH - 1; i > 0; i--)
      key_hist[i] = key_hist[i-1];
    key_hist[0] = key_acc;
    key_acc = '0;
  endfunction

  function automatic display_word_t clock_tick(input logic key);
    display_word_t w;
    bit second_due;
    int d;
    tick_cnt = tick_cnt + 1'b1;
    second_due = (tick_cnt >= rate);
    w.digit_select = 6'd1 << scan_pos;
    case (scan_pos)
      3'd0:    d = sc % 10;
      3'd1:    d = sc / 10;
      3'd2:    d = mn % 10;
      3'd3:    d = mn / 10;
      3'd4:    d = hr % 10;
      default: d = hr / 10;
    endcase
    w.segment_pattern = DIGIT_FONT[d];
    if (key) key_acc = key_acc | w.digit_select;
    if (scan_pos == mcdk_pkg::LAST_POS) begin
      scan_pos = '0;
      if (key_acc != 0) apply_keys();
    end else begin
      scan_pos = scan_pos + 1'b1;
    end
    if (second_due) begin
      tick_cnt = tick_cnt - rate;
      sc = sc + 6'd1;
      if (sc >= 6'd60) begin
        sc = '0;
        mn = mn + 6'd1;
        if (mn >= 6'd60) begin
          mn = '0;
          hr = hr + 5'd1;
          if (hr >= 5'd24) hr = '0;
        end
      end
    end
    w.hours = hr;
    w.minutes = mn;
    w.seconds = sc;
    return w;
  endfunction

  // sender: a new word goes up once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_sent) begin
      in_sent = 1'b0;
      if (scan_ticks_pending.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_tvalid <= 1'b1;
        in_tdata <= scan_ticks_pending.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    display_word_t got, want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[5:0], out_tdata[12:6], out_tdata[17:13],
               out_tdata[23:18], out_tdata[29:24]};
        if (display_words_due.size() == 0) begin
          $error("unexpected output word %h", out_tdata);
          mismatches++;
        end else begin
          want = display_words_due.pop_front();
          if (got.digit_select !== want.digit_select) begin
            $error("digit_select: expected %0d, got %0d", want.digit_select, got.digit_select);
            mismatches++;
          end
          if (got.segment_pattern !== want.segment_pattern) begin
            $error("segment_pattern: expected %0d, got %0d",
                   want.segment_pattern, got.segment_pattern);
            mismatches++;
          end
          if (got.hours !== want.hours) begin
            $error("hours: expected %0d, got %0d", want.hours, got.hours);
            mismatches++;
          end
          if (got.minutes !== want.minutes) begin
            $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
            mismatches++;
          end
          if (got.seconds !== want.seconds) begin
            $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        display_words_due.push_back(clock_tick(in_tdata[1]));
        in_sent = 1'b1;
      end
    end
  end

  // six ticks, one per digit; the tick bit is occasionally zero (ignored)
  task automatic push_frame(input logic [mcdk_pkg::DIGITS-1:0] keys, input bit tick_low_first);
    logic tick;
    for (int k = 0; k < mcdk_pkg::DIGITS; k++) begin
      tick = ($urandom_range(19) != 0);
      if (tick_low_first && k == 0) tick = 1'b0;
      scan_ticks_pending.push_back({6'b0, keys[k], tick});
    end
  endtask

  task automatic wait_idle();
    wait (scan_ticks_pending.size() == 0 && !in_tvalid && display_words_due.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly valid time-setting combinations, some empty scans and some key noise
  task automatic play_frames(input int n);
    int r;
    for (int f = 0; f < n; f++) begin
      r = $urandom_range(99);
      if (r < 70)      push_frame(TIME_KEYS[$urandom_range(5)], 1'b0);
      else if (r < 85) push_frame('0, 1'b0);
      else             push_frame(mcdk_pkg::DIGITS'($urandom_range(63)), 1'b0);
    end
    wait_idle();
  endtask

  task automatic set_rate(input logic [mcdk_pkg::TPS_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    rate = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    snd_idle = 34;
    rcv_idle = 72;
    push_frame(mcdk_pkg::KEY_SEC_UP, 1'b1);
    push_frame(mcdk_pkg::KEY_SEC_UP, 1'b0);    // repeat is blocked by the history
    push_frame(mcdk_pkg::KEY_HR_DOWN, 1'b0);
    push_frame(6'h3F, 1'b0);                   // all keys: recorded, no time change
    play_frames(20);
    set_rate(16'd1);
    play_frames(15);

    snd_idle = 72;
    rcv_idle = 34;
    set_rate(16'd7);
    play_frames(15);
    set_rate(16'hFFFF);
    play_frames(15);

    snd_idle = 0;
    rcv_idle = 0;
    // rate zero: a second per tick while the tick counter keeps climbing
    set_rate(16'd0);
    play_frames(10);
    set_rate(16'd2);                 // counter above the rate drains one per tick
    play_frames(20);
    set_rate(16'd13);
    play_frames(15);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && display_words_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mcdk_pkg.sv
rtl/mcdk_display.sv
rtl/mcdk_keys.sv
rtl/mcdk_time.sv
rtl/multiplexed_clock_display_keys.sv
rtl/mcdk_checker.sv
verif/tb_multiplexed_clock_display_keys.sv
